/* rtl/pullup_rise_time_tuner_defines.svh */
// Assertion helpers for the pull-up tuner.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef PULLUP_RISE_TIME_TUNER_DEFINES_SVH
`define PULLUP_RISE_TIME_TUNER_DEFINES_SVH

// Same-cycle implication.
`define PRTT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication.
`define PRTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/prtt_pkg.sv */
package prtt_pkg;

	// Field widths
	localparam int FACTOR_W = 9;
	localparam int MARGIN_W = 12;
	localparam int LBITS_W  = 4;
	localparam int RISE_W   = 16;
	localparam int LEVEL_W  = 8;

	// Shared multiplier: 16 x 9, compares one bit wider
	localparam int MUL_W = RISE_W + FACTOR_W;
	localparam int CMP_W = MUL_W + 1;

	// Widest level code
	localparam int MAX_LEVEL_BITS = 8;

	// History entries needed before a pending change may settle
	localparam int MIN_STABLE_COUNT = 4;

	// Register reset values
	localparam logic [FACTOR_W-1:0] UPPER_RST  = 9'd259;
	localparam logic [FACTOR_W-1:0] LOWER_RST  = 9'd205;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 12'd80;
	localparam logic [LBITS_W-1:0]  LBITS_RST  = 4'd3;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_UPPER  = 2'd0;
	localparam logic [1:0] REG_LOWER  = 2'd1;
	localparam logic [1:0] REG_MARGIN = 2'd2;
	localparam logic [1:0] REG_LBITS  = 2'd3;

	typedef enum logic [2:0] {
		OP_SAMPLE  = 3'd0,
		OP_SWEEP   = 3'd1,
		OP_RECOVER = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_RESTART = 3'd4
	} op_t;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_BAND_U = 10'b0000000010,
		ST_BAND_L = 10'b0000000100,
		ST_MOVE   = 10'b0000001000,
		ST_MARG_X = 10'b0000010000,
		ST_MARG_M = 10'b0000100000,
		ST_SUM    = 10'b0001000000,
		ST_DECIDE = 10'b0010000000,
		ST_CHK    = 10'b0100000000,
		ST_FINISH = 10'b1000000000
	} state_t;

	// Top level code for a level width, clamped to MAX_LEVEL_BITS
	function automatic logic [LEVEL_W-1:0] max_level(input logic [LBITS_W-1:0] bits);
		logic [LBITS_W-1:0] b;
		logic [LEVEL_W:0]   full;
		b = (bits > LBITS_W'(MAX_LEVEL_BITS)) ? LBITS_W'(MAX_LEVEL_BITS) : bits;
		full = (9'd1 << b) - 9'd1;
		return full[LEVEL_W-1:0];
	endfunction

	// n*x strictly inside (sum - n*m, sum + n*m)
	function automatic logic margin_ok(input logic [CMP_W-1:0] nx,
		input logic [CMP_W-1:0] sum, input logic [CMP_W-1:0] nm);
		return (nx < sum + nm) && (nx + nm > sum);
	endfunction

endpackage

/* rtl/pullup_rise_time_tuner.sv */
// Channel   Dir  Handshake             Payload
// in        in   in_valid / in_ready   operation, rise_cycles
// out       out  out_valid / out_ready pullup_level, level_changed, change_pending_flag,
//                                      device_changed, reference_valid
// cfg       in   psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// Non-sample operations: accept plus one cycle to the output register.
// Sample: 1 + 3 (band test, only once a reference exists) + 2 + (count+1)
//   + 1 + (n+2, stability walk, only with a change pending) + 1 cycles, where
//   count and n are history fill before and after the sample; the single
//   16x9 multiplier and one history read per cycle set this figure.
// One item at a time; the next item is taken while a result waits at out.
// A stalled output holds the sequencer in its last state until taken.
// Reset (arst_n) clears all control state; history entries need no clearing.
`include "pullup_rise_time_tuner_defines.svh"

module pullup_rise_time_tuner #(
	parameter int HISTORY_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [15:0] rise_cycles,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  pullup_level,
	output logic        level_changed,
	output logic        change_pending_flag,
	output logic        device_changed,
	output logic        reference_valid,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int HIDX_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = prtt_pkg::RISE_W + CNT_W;
	localparam int FW     = prtt_pkg::FACTOR_W;
	localparam int CW     = prtt_pkg::CMP_W;
	localparam int MW     = prtt_pkg::MUL_W;
	localparam int LW     = prtt_pkg::LEVEL_W;

	// Configuration registers
	logic [FW-1:0]                   upper_q, lower_q;
	logic [prtt_pkg::MARGIN_W-1:0]   margin_q;
	logic [prtt_pkg::LBITS_W-1:0]    lbits_q;

	// Control state
	prtt_pkg::state_t state_q;
	logic [CNT_W-1:0]  count_q, idx_q;
	logic [HIDX_W-1:0] head_q;
	logic              pending_q, seen_q, learned_q, recovered_q;
	logic              level_moved_q, sweep_rising_q, chg_q, pv_q, out_valid_q;
	logic [LW-1:0]     level_q;
	logic [15:0]       ref_q;

	// Datapath registers
	logic [15:0]    hist_q [HISTORY_DEPTH];
	logic [15:0]    x_q;
	logic [MW-1:0]  mul_q, nx_q;
	logic [CW-1:0]  nm_q;
	logic [SUM_W-1:0] sum_q;
	logic           hi_q;

	// Output registers
	logic [LW-1:0] level_out_q;
	logic          chg_out_q, pending_out_q, seen_out_q, learned_out_q;

	// Combinational
	logic [15:0]     mul_a, hist_rd;
	logic [FW-1:0]   mul_b;
	logic [HIDX_W-1:0] rd_addr;
	logic [LW-1:0]   maxl;
	logic            accept, cfg_wr, out_load;
	logic            band_lo, down_ok, up_ok;
	logic [LW:0]     lvl_up;
	logic [LW-1:0]   lvl_dn;
	logic            full, within_pre, sample_reset, stab_go;
	logic [CNT_W-1:0] n_new;
	logic [CW-1:0]   sum_new, nm_new, cmp_sum;
	logic            cmp_ok, chk_more, chk_fail, chk_done;
	logic            sw_rise;
	logic [HIDX_W-1:0] head_nxt;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == prtt_pkg::ST_IDLE);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign out_load = (state_q == prtt_pkg::ST_FINISH) && (!out_valid_q || out_ready);
	assign maxl     = prtt_pkg::max_level(lbits_q);

	// Register readback
	always_comb begin
		case (paddr[3:2])
			prtt_pkg::REG_UPPER:  prdata = 32'(upper_q);
			prtt_pkg::REG_LOWER:  prdata = 32'(lower_q);
			prtt_pkg::REG_MARGIN: prdata = 32'(margin_q);
			prtt_pkg::REG_LBITS:  prdata = 32'(lbits_q);
			default:              prdata = 32'd0;
		endcase
	end

	// History read port: head slot while deciding, walk index otherwise
	assign rd_addr = (state_q == prtt_pkg::ST_DECIDE) ? head_q : idx_q[HIDX_W-1:0];
	assign hist_rd = hist_q[rd_addr];

	// Operand select for the shared multiplier
	always_comb begin
		case (state_q)
			prtt_pkg::ST_BAND_U: begin
				mul_a = ref_q;
				mul_b = upper_q;
			end
			prtt_pkg::ST_BAND_L: begin
				mul_a = ref_q;
				mul_b = lower_q;
			end
			prtt_pkg::ST_MARG_X: begin
				mul_a = x_q;
				mul_b = FW'(count_q);
			end
			prtt_pkg::ST_MARG_M, prtt_pkg::ST_SUM: begin
				mul_a = 16'(margin_q);
				mul_b = FW'(count_q);
			end
			prtt_pkg::ST_CHK: begin
				mul_a = hist_rd;
				mul_b = FW'(count_q);
			end
			default: begin
				mul_a = 16'd0;
				mul_b = '0;
			end
		endcase
	end

	// Band test and level step
	assign band_lo = CW'({x_q, 8'd0}) < CW'(mul_q);
	assign lvl_up  = {1'b0, level_q} + 9'd1;
	assign lvl_dn  = level_q - 8'd1;
	assign up_ok   = lvl_up <= {1'b0, maxl};
	assign down_ok = (level_q != '0) && (lvl_dn <= maxl);

	// Margin test against the history before the push
	assign within_pre   = prtt_pkg::margin_ok(CW'(nx_q), CW'(sum_q), CW'(mul_q));
	assign sample_reset = level_moved_q || !within_pre;
	assign full         = (count_q == CNT_W'(HISTORY_DEPTH));
	assign n_new        = full ? count_q : count_q + CNT_W'(1);
	assign stab_go      = pending_q && (n_new >= CNT_W'(prtt_pkg::MIN_STABLE_COUNT));
	assign sum_new      = CW'(sum_q) + CW'(x_q) - (full ? CW'(hist_rd) : CW'(0));
	assign nm_new       = full ? CW'(mul_q) : CW'(mul_q) + CW'(margin_q);
	assign head_nxt     = (head_q == HIDX_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + HIDX_W'(1);

	// Stability walk, one product per cycle, compared from the product register
	assign cmp_sum  = CW'(sum_q);
	assign cmp_ok   = prtt_pkg::margin_ok(CW'(mul_q), cmp_sum, nm_q);
	assign chk_more = idx_q < count_q;
	assign chk_fail = pv_q && !cmp_ok;
	assign chk_done = !chk_more && !pv_q;

	// Sweep direction after the bounce rules
	always_comb begin
		sw_rise = sweep_rising_q;
		if (sw_rise && (level_q >= maxl)) begin
			sw_rise = 1'b0;
		end
		if (!sw_rise && (level_q == '0)) begin
			sw_rise = 1'b1;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= prtt_pkg::UPPER_RST;
			lower_q  <= prtt_pkg::LOWER_RST;
			margin_q <= prtt_pkg::MARGIN_RST;
			lbits_q  <= prtt_pkg::LBITS_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				prtt_pkg::REG_UPPER:  upper_q  <= pwdata[FW-1:0];
				prtt_pkg::REG_LOWER:  lower_q  <= pwdata[FW-1:0];
				prtt_pkg::REG_MARGIN: margin_q <= pwdata[prtt_pkg::MARGIN_W-1:0];
				prtt_pkg::REG_LBITS:  lbits_q  <= pwdata[prtt_pkg::LBITS_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= prtt_pkg::ST_IDLE;
			count_q        <= '0;
			idx_q          <= '0;
			head_q         <= '0;
			pending_q      <= 1'b0;
			seen_q         <= 1'b0;
			learned_q      <= 1'b0;
			recovered_q    <= 1'b0;
			level_moved_q  <= 1'b0;
			sweep_rising_q <= 1'b0;
			chg_q          <= 1'b0;
			pv_q           <= 1'b0;
			out_valid_q    <= 1'b0;
			level_q        <= prtt_pkg::max_level(prtt_pkg::LBITS_RST);
			ref_q          <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				prtt_pkg::ST_IDLE: begin
					if (accept) begin
						chg_q   <= 1'b0;
						state_q <= prtt_pkg::ST_FINISH;
						case (operation)
							prtt_pkg::OP_SAMPLE: begin
								state_q <= learned_q ? prtt_pkg::ST_BAND_U
									: prtt_pkg::ST_MARG_X;
							end
							prtt_pkg::OP_SWEEP: begin
								sweep_rising_q <= sw_rise;
								level_q        <= sw_rise ? level_q + 8'd1 : lvl_dn;
								level_moved_q  <= 1'b1;
								chg_q          <= 1'b1;
							end
							prtt_pkg::OP_RECOVER: begin
								recovered_q   <= 1'b1;
								level_moved_q <= 1'b0;
							end
							prtt_pkg::OP_CLEAR: begin
								seen_q <= 1'b0;
							end
							prtt_pkg::OP_RESTART: begin
								count_q       <= '0;
								head_q        <= '0;
								pending_q     <= 1'b0;
								seen_q        <= 1'b0;
								ref_q         <= '0;
								learned_q     <= 1'b0;
								recovered_q   <= 1'b0;
								level_q       <= maxl;
								level_moved_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				prtt_pkg::ST_BAND_U: state_q <= prtt_pkg::ST_BAND_L;
				prtt_pkg::ST_BAND_L: state_q <= prtt_pkg::ST_MOVE;
				prtt_pkg::ST_MOVE: begin
					// above the upper band steps down, below the lower band steps up
					if (hi_q) begin
						if (down_ok) begin
							level_q       <= lvl_dn;
							level_moved_q <= 1'b1;
							chg_q         <= 1'b1;
						end
					end else if (band_lo) begin
						if (up_ok) begin
							level_q       <= lvl_up[LW-1:0];
							level_moved_q <= 1'b1;
							chg_q         <= 1'b1;
						end
					end
					state_q <= prtt_pkg::ST_MARG_X;
				end
				prtt_pkg::ST_MARG_X: begin
					idx_q   <= '0;
					state_q <= prtt_pkg::ST_MARG_M;
				end
				prtt_pkg::ST_MARG_M: state_q <= prtt_pkg::ST_SUM;
				prtt_pkg::ST_SUM: begin
					if (idx_q < count_q) begin
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						state_q <= prtt_pkg::ST_DECIDE;
					end
				end
				prtt_pkg::ST_DECIDE: begin
					level_moved_q <= 1'b0;
					if (sample_reset) begin
						count_q   <= CNT_W'(1);
						head_q    <= HIDX_W'(1);
						pending_q <= 1'b1;
						state_q   <= prtt_pkg::ST_FINISH;
					end else begin
						count_q <= n_new;
						head_q  <= head_nxt;
						idx_q   <= '0;
						pv_q    <= 1'b0;
						state_q <= stab_go ? prtt_pkg::ST_CHK : prtt_pkg::ST_FINISH;
					end
				end
				prtt_pkg::ST_CHK: begin
					if (chk_more) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					pv_q <= chk_more;
					if (chk_fail) begin
						state_q <= prtt_pkg::ST_FINISH;
					end else if (chk_done) begin
						// pending change has settled
						pending_q <= 1'b0;
						seen_q    <= 1'b1;
						if (!learned_q && recovered_q) begin
							ref_q     <= x_q;
							learned_q <= 1'b1;
						end
						state_q <= prtt_pkg::ST_FINISH;
					end
				end
				prtt_pkg::ST_FINISH: begin
					if (out_load) begin
						state_q <= prtt_pkg::ST_IDLE;
					end
				end
				default: state_q <= prtt_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath: multiplier, accumulator, history and result registers
	always_ff @(posedge clk) begin
		mul_q <= MW'(mul_a * mul_b);
		if (accept) begin
			x_q <= rise_cycles;
		end
		case (state_q)
			prtt_pkg::ST_BAND_L: hi_q <= CW'({x_q, 8'd0}) > CW'(mul_q);
			prtt_pkg::ST_MARG_X: sum_q <= '0;
			prtt_pkg::ST_MARG_M: nx_q <= mul_q;
			prtt_pkg::ST_SUM: begin
				if (idx_q < count_q) begin
					sum_q <= sum_q + SUM_W'(hist_rd);
				end
			end
			prtt_pkg::ST_DECIDE: begin
				if (sample_reset) begin
					hist_q[0] <= x_q;
				end else begin
					hist_q[head_q] <= x_q;
				end
				sum_q <= sum_new[SUM_W-1:0];
				nm_q  <= nm_new;
			end
			default: ;
		endcase
		if (out_load) begin
			level_out_q   <= level_q;
			chg_out_q     <= chg_q;
			pending_out_q <= pending_q;
			seen_out_q    <= seen_q;
			learned_out_q <= learned_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign pullup_level        = level_out_q;
	assign level_changed       = chg_out_q;
	assign change_pending_flag = pending_out_q;
	assign device_changed      = seen_out_q;
	assign reference_valid     = learned_out_q;

	// Checks
	`PRTT_ASSERT_NEXT(a_short_op, accept && (operation != prtt_pkg::OP_SAMPLE), state_q == prtt_pkg::ST_FINISH)
	`PRTT_ASSERT_NEXT(a_decide_push, state_q == prtt_pkg::ST_DECIDE, !level_moved_q && (count_q != '0))
	`PRTT_ASSERT_NEXT(a_settle, (state_q == prtt_pkg::ST_CHK) && chk_done, seen_q && !pending_q)
	`PRTT_ASSERT_NEXT(a_load, out_load, out_valid_q && (state_q == prtt_pkg::ST_IDLE))
	`PRTT_ASSERT_IMP(a_fill, 1'b1, count_q <= CNT_W'(HISTORY_DEPTH))

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
	import prtt_pkg::*;

	localparam int HIST_DEPTH = 8;
	// Operation codes the block does not decode
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [7:0] level;
		logic       moved;
		logic       pending;
		logic       seen;
		logic       learned;
	} tuner_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  operation = OP_SAMPLE;
	logic [15:0] rise_cycles = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  pullup_level;
	logic        level_changed;
	logic        change_pending_flag;
	logic        device_changed;
	logic        reference_valid;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	pullup_rise_time_tuner #(.HISTORY_DEPTH(HIST_DEPTH)) dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the tuning registers and tuner state
	int unsigned upper_f, lower_f, margin_q4, width_bits;
	logic [15:0] hist_mem [HIST_DEPTH];
	int unsigned hist_fill, hist_wr;
	bit pend_chg, dev_chg, ref_known, recovered, just_moved, sweep_up;
	int unsigned ref_rise, cur_level;

	tuner_result_t tuner_results_due[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int unsigned beats_sent = 0, samples_sent = 0, results_checked = 0;
	int unsigned level_moves = 0, device_events = 0, refs_learned = 0;
	int unsigned settings_used = 0, failures = 0;

	// Top level code for the current width, clamped to the widest level
	function automatic int unsigned level_ceiling();
		int unsigned b;
		b = (width_bits > MAX_LEVEL_BITS) ? MAX_LEVEL_BITS : width_bits;
		return (32'd1 << b) - 1;
	endfunction

	function automatic longint unsigned history_total();
		longint unsigned acc;
		acc = 0;
		for (int i = 0; i < hist_fill && i < HIST_DEPTH; i++)
			acc += hist_mem[i];
		return acc;
	endfunction

	// n*x strictly inside sum -/+ n*margin
	function automatic bit near_average(input longint unsigned x,
		input longint unsigned total, input longint unsigned n);
		longint unsigned nx, nm;
		nx = n * x;
		nm = n * margin_q4;
		return (nx < total + nm) && (nx + nm > total);
	endfunction

	function automatic void history_append(input logic [15:0] x);
		hist_mem[hist_wr] = x;
		hist_wr = (hist_wr + 1) % HIST_DEPTH;
		if (hist_fill < HIST_DEPTH)
			hist_fill++;
	endfunction

	// Empty history never settles
	function automatic bit history_settled();
		longint unsigned total;
		total = history_total();
		if (hist_fill == 0)
			return 1'b0;
		for (int i = 0; i < hist_fill && i < HIST_DEPTH; i++)
			if (!near_average(hist_mem[i], total, hist_fill))
				return 1'b0;
		return 1'b1;
	endfunction

	// One step of the level, refused past zero or the ceiling
	function automatic bit step_level(input bit up);
		int unsigned nxt;
		if (!up && cur_level == 0)
			return 1'b0;
		nxt = up ? cur_level + 1 : cur_level - 1;
		if (nxt > level_ceiling())
			return 1'b0;
		cur_level = nxt & 32'hFF;
		just_moved = 1'b1;
		level_moves++;
		return 1'b1;
	endfunction

	// Everything but the sweep direction and the registers
	function automatic void clear_tuner_state();
		hist_fill = 0;
		hist_wr = 0;
		pend_chg = 1'b0;
		dev_chg = 1'b0;
		ref_rise = 0;
		ref_known = 1'b0;
		recovered = 1'b0;
		cur_level = level_ceiling();
		just_moved = 1'b0;
	endfunction

	function automatic tuner_result_t predict_tuner_result(input logic [2:0] op,
		input logic [15:0] rise);
		tuner_result_t res;
		bit moved_now;
		int unsigned scaled;
		moved_now = 1'b0;
		case (op)
			OP_SAMPLE: begin
				samples_sent++;
				if (ref_known) begin
					scaled = int'(rise) << 8;
					if (scaled > ref_rise * upper_f)
						moved_now = step_level(1'b0);
					else if (scaled < ref_rise * lower_f)
						moved_now = step_level(1'b1);
				end
				if (just_moved || !near_average(rise, history_total(), hist_fill)) begin
					hist_fill = 0;
					hist_wr = 0;
					history_append(rise);
					pend_chg = 1'b1;
				end else begin
					history_append(rise);
					if (pend_chg && hist_fill >= MIN_STABLE_COUNT && history_settled()) begin
						pend_chg = 1'b0;
						dev_chg = 1'b1;
						device_events++;
						if (!ref_known && recovered) begin
							ref_rise = rise;
							ref_known = 1'b1;
							refs_learned++;
						end
					end
				end
				just_moved = 1'b0;
			end
			OP_SWEEP: begin
				// bounce at the ceiling when rising and at zero when falling
				if (sweep_up && cur_level >= level_ceiling())
					sweep_up = 1'b0;
				if (!sweep_up && cur_level == 0)
					sweep_up = 1'b1;
				cur_level = (sweep_up ? cur_level + 1 : cur_level - 1) & 32'hFF;
				just_moved = 1'b1;
				moved_now = 1'b1;
				level_moves++;
			end
			OP_RECOVER: begin
				recovered = 1'b1;
				just_moved = 1'b0;
			end
			OP_CLEAR: dev_chg = 1'b0;
			OP_RESTART: clear_tuner_state();
			default: ;
		endcase
		res.level = cur_level[7:0];
		res.moved = moved_now;
		res.pending = pend_chg;
		res.seen = dev_chg;
		res.learned = ref_known;
		return res;
	endfunction

	// Result checker
	always @(posedge clk) begin
		tuner_result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {pullup_level, level_changed, change_pending_flag, device_changed,
				reference_valid};
			if (tuner_results_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result beat with nothing outstanding", $realtime);
			end else begin
				want = tuner_results_due.pop_front();
				results_checked++;
				if (got !== want) begin
					failures++;
					if (failures <= 10)
						$display({"%0t: mismatch (exp/got) level %0d/%0d changed %0b/%0b",
							" pending %0b/%0b device %0b/%0b reference %0b/%0b"},
							$realtime, want.level, got.level, want.moved, got.moved,
							want.pending, got.pending, want.seen, got.seen,
							want.learned, got.learned);
				end
			end
		end
	end

	// Receiver stalls
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic send_beat(input logic [2:0] op, input logic [15:0] rise);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rise_cycles <= rise;
		do begin
			@(posedge clk);
		end while (!in_ready);
		tuner_results_due.push_back(predict_tuner_result(op, rise));
		beats_sent++;
	endtask

	// Hold off input until every outstanding result is out
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tuner_results_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] index, input int unsigned value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		case (index)
			REG_UPPER:  upper_f = value & 32'h1FF;
			REG_LOWER:  lower_f = value & 32'h1FF;
			REG_MARGIN: margin_q4 = value & 32'hFFF;
			REG_LBITS:  width_bits = value & 32'hF;
			default: ;
		endcase
	endtask

	task automatic apply_tuning(input int unsigned up_f, input int unsigned lo_f,
		input int unsigned margin, input int unsigned lbits);
		wait_drained();
		write_register(REG_UPPER, up_f);
		write_register(REG_LOWER, lo_f);
		write_register(REG_MARGIN, margin);
		write_register(REG_LBITS, lbits);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		settings_used++;
	endtask

	// Rotate through defaults, both extremes and random settings
	task automatic choose_tuning();
		case (settings_used % 6)
			0: apply_tuning(UPPER_RST, LOWER_RST, MARGIN_RST, LBITS_RST);
			1: apply_tuning(511, 0, 4095, MAX_LEVEL_BITS);
			2: apply_tuning(0, 511, 0, 1);
			3: apply_tuning($urandom_range(511), $urandom_range(511),
				$urandom_range(4095), $urandom_range(15));
			4: apply_tuning(256 + $urandom_range(64), 128 + $urandom_range(127),
				8 + $urandom_range(400), $urandom_range(MAX_LEVEL_BITS, 1));
			default: apply_tuning(511, 511, 1, 15);
		endcase
	endtask

	function automatic int pick_rise();
		case ($urandom_range(3))
			0: return $urandom_range(255);
			1: return 65535 - $urandom_range(255);
			default: return $urandom_range(65535);
		endcase
	endfunction

	// A run of samples that sit close together, usually centred in the band once a reference is known
	task automatic send_stable_burst();
		int center, jitter, len, lo, hi, x;
		len = $urandom_range(9, 4);
		jitter = margin_q4 / 3;
		center = pick_rise();
		if (ref_known && $urandom_range(99) < 70) begin
			lo = (ref_rise * lower_f + 255) / 256;
			hi = (ref_rise * upper_f) / 256;
			if (hi > 65535)
				hi = 65535;
			if (lo <= hi) begin
				center = (lo + hi) / 2;
				if (jitter > (hi - lo) / 2)
					jitter = (hi - lo) / 2;
			end
		end
		if (jitter > 2000)
			jitter = 2000;
		if (!recovered && $urandom_range(1))
			send_beat(OP_RECOVER, 16'($urandom));
		repeat (len) begin
			x = center + int'($urandom_range(2 * jitter)) - jitter;
			if (x < 0)
				x = 0;
			if (x > 65535)
				x = 65535;
			send_beat(OP_SAMPLE, x[15:0]);
		end
	endtask

	task automatic test_each_operation();
		send_beat(OP_SAMPLE, 16'h0000);
		send_beat(OP_SAMPLE, 16'hFFFF);
		send_beat(OP_SWEEP, 16'hFFFF);
		send_beat(OP_RECOVER, 16'h0000);
		send_beat(OP_CLEAR, 16'h5A5A);
		send_beat(OP_UNUSED_LO, 16'hA5A5);
		send_beat(OP_UNUSED_HI, 16'h0000);
		send_beat(OP_RESTART, 16'hFFFF);
	endtask

	// Learn a reference after recovery, then push out of both band edges
	task automatic test_reference_learning();
		send_beat(OP_RECOVER, 16'h0000);
		repeat (4)
			send_beat(OP_SAMPLE, 16'd1600);
		send_beat(OP_SAMPLE, 16'd2000);
		send_beat(OP_SAMPLE, 16'd1000);
		send_beat(OP_CLEAR, 16'h0000);
	endtask

	// Zero-width bounce, widest level, level left above a narrowed ceiling
	task automatic test_level_width_edges();
		apply_tuning(UPPER_RST, LOWER_RST, MARGIN_RST, 0);
		send_beat(OP_RESTART, 16'h0000);
		repeat (3)
			send_beat(OP_SWEEP, 16'h0000);
		apply_tuning(UPPER_RST, LOWER_RST, MARGIN_RST, MAX_LEVEL_BITS);
		send_beat(OP_RESTART, 16'h0000);
		send_beat(OP_SWEEP, 16'h0000);
		apply_tuning(UPPER_RST, LOWER_RST, MARGIN_RST, 2);
		send_beat(OP_SWEEP, 16'h0000);
		send_beat(OP_SAMPLE, 16'd500);
	endtask

	task automatic test_random_traffic(input int unsigned beats);
		int unsigned stop_at, block_end, roll;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			choose_tuning();
			block_end = beats_sent + 120;
			while (beats_sent < block_end && beats_sent < stop_at) begin
				roll = $urandom_range(99);
				if (roll < 50)
					send_stable_burst();
				else if (roll < 60)
					send_beat(OP_RECOVER, 16'($urandom));
				else if (roll < 68)
					send_beat(OP_SWEEP, 16'($urandom));
				else if (roll < 72)
					send_beat(OP_CLEAR, 16'($urandom));
				else if (roll < 75)
					send_beat(OP_RESTART, 16'($urandom));
				else if (roll < 78)
					send_beat($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO), 16'($urandom));
				else
					send_beat(OP_SAMPLE, 16'(pick_rise()));
			end
		end
	endtask

	initial begin
		upper_f = UPPER_RST;
		lower_f = LOWER_RST;
		margin_q4 = MARGIN_RST;
		width_bits = LBITS_RST;
		sweep_up = 1'b0;
		clear_tuner_state();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 14;
		recv_idle_pct = 62;
		test_each_operation();
		test_reference_learning();
		test_level_width_edges();
		test_random_traffic(600);
		send_idle_pct = 62;
		recv_idle_pct = 14;
		test_random_traffic(600);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(550);

		wait_drained();
		repeat (40) @(negedge clk);
		$display("Run covered %0d beats (%0d samples) over %0d register settings, %0d results checked",
			beats_sent, samples_sent, settings_used, results_checked);
		$display("References learned %0d times, %0d level moves, %0d device-change events",
			refs_learned, level_moves, device_events);
		if (failures == 0 && tuner_results_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d failures, %0d results outstanding", failures,
				tuner_results_due.size());
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* pullup_rise_time_tuner.f */
+incdir+rtl
rtl/prtt_pkg.sv
rtl/pullup_rise_time_tuner.sv
sim/tb.sv
